// ===== src/idda_pkg.sv =====
// Shared constants, types and command format for the incoherent dedispersion unit.
// No dependencies; every other file refers to it by scoped names.
`default_nettype none
package idda_pkg;
  localparam int NUM_CHANNELS = 256;
  localparam int MAX_DELAY    = 511;
  localparam int RING_DEPTH   = 1024;
  localparam int SAMPLE_BITS  = 16;

  localparam int REQ_W  = 2;
  localparam int CH_W   = 8;
  localparam int VAL_W  = 16;
  localparam int TIME_W = 32;
  localparam int AVG_W  = 16;
  localparam int SUM_W  = 24;
  localparam int CNT_W  = 9;
  localparam int CNT_MAX = 511;

  localparam int SAMP_W    = (SAMPLE_BITS < 16) ? SAMPLE_BITS : 16;
  localparam int DLY_W     = $clog2(MAX_DELAY + 1) + 1;
  localparam int DLY_DEPTH = (NUM_CHANNELS < 256) ? NUM_CHANNELS : 256;
  localparam int DLY_AW    = $clog2(DLY_DEPTH);
  localparam int RING_AW   = $clog2(RING_DEPTH);
  localparam int SLOT_W    = ((RING_AW > DLY_W) ? RING_AW : DLY_W) + 2;
  localparam int ACC_W     = SUM_W + CNT_W;
  localparam int DIV_STEPS = SUM_W;
  localparam int DIV_CW    = $clog2(DIV_STEPS + 1);

  localparam int QUEUE_DEPTH = 4;
  localparam int Q_AW        = 2;

  typedef enum logic [REQ_W-1:0] {
    REQ_LOAD   = 2'd0,
    REQ_SAMPLE = 2'd1,
    REQ_FLUSH  = 2'd2,
    REQ_NONE   = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    OP_LOAD,
    OP_SAMPLE,
    OP_TICK
  } op_t;

  typedef struct packed {
    op_t              op;
    logic [CH_W-1:0]  channel;
    logic [VAL_W-1:0] value;
    logic             end_step;
  } cmd_t;

  typedef struct packed {
    logic wr_en;
    cmd_t wr_data;
  } q_push_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;
endpackage
`default_nettype wire

// ===== src/idda_if.sv =====
// Channel interfaces: request stream into the unit and result stream out of it.
// Depends on idda_pkg for field widths.
`default_nettype none
interface idda_in_if;
  logic                         valid;
  logic                         ready;
  logic [idda_pkg::REQ_W-1:0]   req_type;
  logic [idda_pkg::CH_W-1:0]    channel;
  logic signed [idda_pkg::VAL_W-1:0] value;
  logic                         end_of_time;
  modport source (output valid, req_type, channel, value, end_of_time, input ready);
  modport sink   (input valid, req_type, channel, value, end_of_time, output ready);
endinterface

interface idda_out_if;
  logic                         valid;
  logic                         ready;
  logic [idda_pkg::TIME_W-1:0]  time_index;
  logic signed [idda_pkg::AVG_W-1:0] average;
  logic                         empty_res;
  modport source (output valid, time_index, average, empty_res, input ready);
  modport sink   (input valid, time_index, average, empty_res, output ready);
endinterface
`default_nettype wire

// ===== src/idda_front.sv =====
// Front end: accepts requests, drops the ones with no effect, saturates delays
// and pushes commands into the queue. Depends on idda_pkg and idda_if.
`default_nettype none
module idda_front (
  idda_in_if.sink             samples,
  input  var idda_pkg::q_stat_t q_stat,
  input  var logic            busy,
  output idda_pkg::q_push_t   push
);
  logic accept;
  logic in_range;
  int   v_int;
  logic signed [idda_pkg::VAL_W-1:0] sat_dly;

  assign samples.ready = !q_stat.full && !busy;
  assign accept        = samples.valid && samples.ready;
  assign in_range      = int'(samples.channel) < idda_pkg::NUM_CHANNELS;
  assign v_int         = int'(samples.value);

  always_comb begin
    if (v_int > idda_pkg::MAX_DELAY) begin
      sat_dly = idda_pkg::VAL_W'(idda_pkg::MAX_DELAY);
    end else if (v_int < -idda_pkg::MAX_DELAY) begin
      sat_dly = idda_pkg::VAL_W'(-idda_pkg::MAX_DELAY);
    end else begin
      sat_dly = samples.value;
    end
  end

  always_comb begin
    push.wr_en            = 1'b0;
    push.wr_data.op       = idda_pkg::OP_TICK;
    push.wr_data.channel  = samples.channel;
    push.wr_data.value    = samples.value;
    push.wr_data.end_step = 1'b1;
    unique case (idda_pkg::req_t'(samples.req_type))
      idda_pkg::REQ_LOAD: begin
        push.wr_en            = accept && in_range;
        push.wr_data.op       = idda_pkg::OP_LOAD;
        push.wr_data.value    = sat_dly;
        push.wr_data.end_step = 1'b0;
      end
      idda_pkg::REQ_SAMPLE: begin
        // out-of-range channel still ends the time step when marked
        push.wr_en            = accept && (in_range || samples.end_of_time);
        push.wr_data.op       = in_range ? idda_pkg::OP_SAMPLE : idda_pkg::OP_TICK;
        push.wr_data.end_step = samples.end_of_time;
      end
      idda_pkg::REQ_FLUSH: begin
        push.wr_en = accept;
      end
      idda_pkg::REQ_NONE: begin
        push.wr_en = 1'b0;
      end
      default: begin
        push.wr_en = 1'b0;
      end
    endcase
  end
endmodule
`default_nettype wire

// ===== src/idda_queue.sv =====
// Short command queue between the front end and the back end.
// Depends on idda_pkg.
`default_nettype none
module idda_queue (
  input  var logic              clk,
  input  var logic              rst,
  input  var idda_pkg::q_push_t push,
  input  var logic              rd_en,
  output idda_pkg::cmd_t        rd_data,
  output idda_pkg::q_stat_t     stat
);
  idda_pkg::cmd_t           mem [idda_pkg::QUEUE_DEPTH];
  logic [idda_pkg::Q_AW-1:0] wr_ptr;
  logic [idda_pkg::Q_AW-1:0] rd_ptr;
  logic [idda_pkg::Q_AW:0]   count;
  logic                     do_wr;
  logic                     do_rd;

  assign stat.full  = count == (idda_pkg::Q_AW + 1)'(idda_pkg::QUEUE_DEPTH);
  assign stat.empty = count == '0;
  assign do_wr      = push.wr_en && !stat.full;
  assign do_rd      = rd_en && !stat.empty;
  assign rd_data    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= push.wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) wr_ptr <= wr_ptr + 1'b1;
      if (do_rd) rd_ptr <= rd_ptr + 1'b1;
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end
endmodule
`default_nettype wire

// ===== src/idda_div.sv =====
// Restoring divider, one quotient bit per cycle, for slot sum over count.
// Depends on idda_pkg.
`default_nettype none
module idda_div (
  input  var logic                        clk,
  input  var logic                        rst,
  input  var logic                        start,
  input  var logic [idda_pkg::SUM_W-1:0]  dividend,
  input  var logic [idda_pkg::CNT_W-1:0]  divisor,
  output logic                            done,
  output logic [idda_pkg::SUM_W-1:0]      quotient
);
  logic [idda_pkg::CNT_W-1:0]  dsr;
  logic [idda_pkg::CNT_W:0]    rem;
  logic [idda_pkg::CNT_W:0]    rem_sh;
  logic [idda_pkg::DIV_CW-1:0] steps;
  logic                        running;
  logic                        fits;

  assign rem_sh = {rem[idda_pkg::CNT_W-1:0], quotient[idda_pkg::SUM_W-1]};
  assign fits   = rem_sh >= {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      steps   <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running  <= 1'b1;
        steps    <= '0;
        rem      <= '0;
        dsr      <= divisor;
        quotient <= dividend;
      end else if (running) begin
        // shift in the next dividend bit, subtract where it fits
        rem      <= fits ? (rem_sh - {1'b0, dsr}) : rem_sh;
        quotient <= {quotient[idda_pkg::SUM_W-2:0], fits};
        steps    <= steps + 1'b1;
        if (steps == idda_pkg::DIV_CW'(idda_pkg::DIV_STEPS - 1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire

// ===== src/idda_back.sv =====
// Back end: delay table, accumulator ring, time counter and result register.
// Depends on idda_pkg, idda_if and idda_div.
`default_nettype none
module idda_back (
  input  var logic             clk,
  input  var logic             rst,
  input  var idda_pkg::cmd_t   cmd,
  input  var logic             q_empty,
  output logic                 pop,
  output logic                 busy,
  idda_out_if.source           results
);
  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_DLY, S_ACC, S_EMIT, S_CHK, S_DIV, S_OUT
  } state_t;

  state_t state;

  logic signed [idda_pkg::DLY_W-1:0] dly_mem [idda_pkg::DLY_DEPTH];
  logic [idda_pkg::DLY_DEPTH-1:0]    dly_vld;
  logic signed [idda_pkg::DLY_W-1:0] dly_q;
  logic                              dly_vld_q;

  logic [idda_pkg::ACC_W-1:0]   acc_mem [idda_pkg::RING_DEPTH];
  logic [idda_pkg::ACC_W-1:0]   acc_q;
  logic [idda_pkg::RING_AW-1:0] acc_raddr;
  logic [idda_pkg::RING_AW-1:0] acc_waddr;
  logic [idda_pkg::ACC_W-1:0]   acc_wdata;
  logic                         acc_we;

  idda_pkg::cmd_t               cur;
  logic [idda_pkg::TIME_W-1:0]  time_counter;
  logic [idda_pkg::RING_AW-1:0] ring_pos;
  logic                         warm;
  logic [idda_pkg::RING_AW-1:0] clr_addr;
  logic [idda_pkg::RING_AW-1:0] slot_r;
  logic                         drop_r;
  logic                         neg_r;

  logic [idda_pkg::DLY_AW-1:0]       dly_idx;
  logic signed [idda_pkg::DLY_W-1:0] delay;
  logic [idda_pkg::RING_AW-1:0]      slot_samp;
  logic [idda_pkg::RING_AW-1:0]      slot_emit;
  logic                              drop;
  logic                              emit_ok;

  logic signed [idda_pkg::SUM_W-1:0] acc_sum;
  logic [idda_pkg::CNT_W-1:0]        acc_cnt;
  logic signed [idda_pkg::SUM_W:0]   sum_ext;
  logic [idda_pkg::SUM_W-1:0]        sum_new;
  logic [idda_pkg::SUM_W-1:0]        sum_mag;

  logic                       div_start;
  logic                       div_done;
  logic [idda_pkg::SUM_W-1:0] div_q;
  logic signed [idda_pkg::AVG_W-1:0] avg_sat;

  function automatic logic [idda_pkg::RING_AW-1:0] wrap_slot(
    input logic signed [idda_pkg::SLOT_W-1:0] t
  );
    logic signed [idda_pkg::SLOT_W-1:0] r;
    begin
      r = t;
      if (t < 0) begin
        r = t + idda_pkg::SLOT_W'(idda_pkg::RING_DEPTH);
      end else if (t >= idda_pkg::SLOT_W'(idda_pkg::RING_DEPTH)) begin
        r = t - idda_pkg::SLOT_W'(idda_pkg::RING_DEPTH);
      end
      return r[idda_pkg::RING_AW-1:0];
    end
  endfunction

  assign dly_idx = cmd.channel[idda_pkg::DLY_AW-1:0];
  assign delay   = dly_vld_q ? dly_q : '0;
  assign busy    = state == S_CLEAR;

  assign slot_samp = wrap_slot(idda_pkg::SLOT_W'($signed({1'b0, ring_pos}))
                               + idda_pkg::SLOT_W'(delay));
  assign slot_emit = wrap_slot(idda_pkg::SLOT_W'($signed({1'b0, ring_pos}))
                               - idda_pkg::SLOT_W'(idda_pkg::MAX_DELAY));
  // before the first output, drop samples whose output time is negative
  assign drop    = !warm && delay[idda_pkg::DLY_W-1]
                   && (time_counter < idda_pkg::TIME_W'(-delay));
  assign emit_ok = warm || (time_counter >= idda_pkg::TIME_W'(idda_pkg::MAX_DELAY));

  assign acc_sum = acc_q[idda_pkg::ACC_W-1:idda_pkg::CNT_W];
  assign acc_cnt = acc_q[idda_pkg::CNT_W-1:0];
  assign sum_ext = {acc_sum[idda_pkg::SUM_W-1], acc_sum}
                   + (idda_pkg::SUM_W + 1)'($signed(cur.value[idda_pkg::SAMP_W-1:0]));
  assign sum_mag = acc_sum[idda_pkg::SUM_W-1] ? (~acc_sum + 1'b1) : acc_sum;

  always_comb begin
    unique case (sum_ext[idda_pkg::SUM_W:idda_pkg::SUM_W-1])
      2'b01:   sum_new = {1'b0, {(idda_pkg::SUM_W-1){1'b1}}};
      2'b10:   sum_new = {1'b1, {(idda_pkg::SUM_W-1){1'b0}}};
      default: sum_new = sum_ext[idda_pkg::SUM_W-1:0];
    endcase
  end

  always_comb begin
    if (neg_r) begin
      if (div_q > idda_pkg::SUM_W'(32768)) begin
        avg_sat = idda_pkg::AVG_W'(-32768);
      end else begin
        avg_sat = idda_pkg::AVG_W'(~div_q + 1'b1);
      end
    end else if (div_q > idda_pkg::SUM_W'(32767)) begin
      avg_sat = idda_pkg::AVG_W'(32767);
    end else begin
      avg_sat = idda_pkg::AVG_W'(div_q);
    end
  end

  always_comb begin
    acc_raddr = (state == S_DLY) ? slot_samp : slot_emit;
    acc_we    = 1'b0;
    acc_waddr = slot_r;
    acc_wdata = '0;
    unique case (state)
      S_CLEAR: begin
        acc_we    = 1'b1;
        acc_waddr = clr_addr;
      end
      S_ACC: begin
        acc_we    = !drop_r && (acc_cnt < idda_pkg::CNT_W'(idda_pkg::CNT_MAX));
        acc_wdata = {sum_new, acc_cnt + 1'b1};
      end
      S_CHK: begin
        acc_we = 1'b1;
      end
      default: begin
        acc_we = 1'b0;
      end
    endcase
  end

  assign pop       = (state == S_IDLE) && !q_empty;
  assign div_start = (state == S_CHK) && (acc_cnt != '0);

  always_ff @(posedge clk) begin
    acc_q <= acc_mem[acc_raddr];
    if (acc_we) begin
      acc_mem[acc_waddr] <= acc_wdata;
    end
    dly_q     <= dly_mem[dly_idx];
    dly_vld_q <= dly_vld[dly_idx];
    if (pop && (cmd.op == idda_pkg::OP_LOAD)) begin
      dly_mem[dly_idx] <= cmd.value[idda_pkg::DLY_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dly_vld <= '0;
    end else if (pop && (cmd.op == idda_pkg::OP_LOAD)) begin
      dly_vld[dly_idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_CLEAR;
      clr_addr      <= '0;
      time_counter  <= '0;
      ring_pos      <= '0;
      warm          <= 1'b0;
      results.valid <= 1'b0;
    end else begin
      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == idda_pkg::RING_AW'(idda_pkg::RING_DEPTH - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (pop) begin
            cur <= cmd;
            unique case (cmd.op)
              idda_pkg::OP_LOAD:   state <= S_IDLE;
              idda_pkg::OP_SAMPLE: state <= S_DLY;
              idda_pkg::OP_TICK:   state <= S_EMIT;
              default:             state <= S_IDLE;
            endcase
          end
        end
        S_DLY: begin
          slot_r <= slot_samp;
          drop_r <= drop;
          state  <= S_ACC;
        end
        S_ACC: begin
          state <= cur.end_step ? S_EMIT : S_IDLE;
        end
        S_EMIT: begin
          slot_r <= slot_emit;
          if (emit_ok) begin
            state <= S_CHK;
          end else begin
            // warm-up: advance time without a result
            time_counter <= time_counter + 1'b1;
            ring_pos     <= (ring_pos == idda_pkg::RING_AW'(idda_pkg::RING_DEPTH - 1))
                            ? '0 : ring_pos + 1'b1;
            state        <= S_IDLE;
          end
        end
        S_CHK: begin
          results.time_index <= time_counter - idda_pkg::TIME_W'(idda_pkg::MAX_DELAY);
          neg_r              <= acc_sum[idda_pkg::SUM_W-1];
          if (acc_cnt == '0) begin
            results.average   <= '0;
            results.empty_res <= 1'b1;
            results.valid     <= 1'b1;
            state             <= S_OUT;
          end else begin
            results.empty_res <= 1'b0;
            state             <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_done) begin
            results.average <= avg_sat;
            results.valid   <= 1'b1;
            state           <= S_OUT;
          end
        end
        S_OUT: begin
          if (results.ready) begin
            results.valid <= 1'b0;
            warm          <= 1'b1;
            time_counter  <= time_counter + 1'b1;
            ring_pos      <= (ring_pos == idda_pkg::RING_AW'(idda_pkg::RING_DEPTH - 1))
                             ? '0 : ring_pos + 1'b1;
            state         <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  idda_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (sum_mag),
    .divisor  (acc_cnt),
    .done     (div_done),
    .quotient (div_q)
  );
endmodule
`default_nettype wire

// ===== src/incoherent_dedispersion_average_unit.sv =====
// Incoherent dedispersion with per-time-step averaging: top level.
// Depends on idda_pkg, idda_if, idda_front, idda_queue and idda_back.
//
// Channels: "samples" takes requests (load delay, channel sample, flush tick);
// "results" gives one averaged value per ended time step once warmed up.
// Both use valid/ready; a transfer happens when both are high.
// The front end takes a request per cycle into a four-entry command queue, while
// that is not full and no clearing runs; the back end works one command at a time:
//   delay load      delay table write
//   channel sample  delay table read, ring read, ring write
//   end of step     emit slot read and check, a divider run unless the slot is
//                   empty, then the result presented until taken;
//                   during warm-up only the time advance and no result.
// The sustained sample rate is set by the ring read-modify-write; an end of step
// adds the divider run (none for an empty slot), plus any time the receiver
// stalls the result. Reset: a clearing pass writes zero to all 1024 ring slots,
// one per cycle; samples.ready stays low throughout the pass. Delays read as
// zero until loaded. When the receiver stalls, the back end holds its result
// and the queue fills; samples.ready falls once the queue is full.
`default_nettype none
module incoherent_dedispersion_average_unit (
  input  var logic   clk,
  input  var logic   rst,
  idda_in_if.sink    samples,
  idda_out_if.source results
);
  idda_pkg::q_push_t push;
  idda_pkg::q_stat_t q_stat;
  idda_pkg::cmd_t    q_head;
  logic              pop;
  logic              busy;

  idda_front u_front (
    .samples (samples),
    .q_stat  (q_stat),
    .busy    (busy),
    .push    (push)
  );

  idda_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .rd_en   (pop),
    .rd_data (q_head),
    .stat    (q_stat)
  );

  idda_back u_back (
    .clk     (clk),
    .rst     (rst),
    .cmd     (q_head),
    .q_empty (q_stat.empty),
    .pop     (pop),
    .busy    (busy),
    .results (results)
  );
endmodule
`default_nettype wire

// ===== src/idda_checker.sv =====
// Port-level checks for the dedispersion unit, attached by bind.
// Depends on idda_pkg and the top level's ports.
`default_nettype none
module idda_checker (
  input var logic                              clk,
  input var logic                              rst,
  input var logic                              in_ready,
  input var logic                              out_valid,
  input var logic                              out_ready,
  input var logic [idda_pkg::TIME_W-1:0]       time_index,
  input var logic signed [idda_pkg::AVG_W-1:0] average,
  input var logic                              empty_res
);
  // clearing pass follows reset
  a_clear_after_rst: assert property (@(posedge clk) rst |=> !in_ready)
    else $error("ready high right after reset");

  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && empty_res |-> average == '0)
    else $error("empty result with nonzero average");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(time_index))
    else $error("stalled result changed");

  a_gap: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready |=> !out_valid)
    else $error("result right after transfer");
endmodule

bind incoherent_dedispersion_average_unit idda_checker u_idda_checker (
  .clk        (clk),
  .rst        (rst),
  .in_ready   (samples.ready),
  .out_valid  (results.valid),
  .out_ready  (results.ready),
  .time_index (results.time_index),
  .average    (results.average),
  .empty_res  (results.empty_res)
);
`default_nettype wire

// ===== verif/incoherent_dedispersion_average_unit_tb.sv =====
// Testbench for the incoherent dedispersion averaging unit: directed table, then random traffic.
// Depends on idda_pkg, idda_if and the unit; results are checked against an in-bench predictor.
`timescale 1ns / 100ps
module incoherent_dedispersion_average_unit_tb;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int TAIL_CYCLES = 100;

  typedef struct {
    logic [idda_pkg::TIME_W-1:0]       t;
    logic signed [idda_pkg::AVG_W-1:0] avg;
    logic                              emp;
  } avg_res_t;

  typedef struct {
    idda_pkg::req_t                    req;
    logic [idda_pkg::CH_W-1:0]         ch;
    logic signed [idda_pkg::VAL_W-1:0] val;
    logic                              eot;
    bit                                typed;
    avg_res_t                          res;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  idda_in_if  samples_if ();
  idda_out_if results_if ();

  incoherent_dedispersion_average_unit i_dut (
    .clk     (clk),
    .rst     (rst),
    .samples (samples_if),
    .results (results_if)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // predictor state
  int signed        dly_tab  [idda_pkg::NUM_CHANNELS];
  longint signed    slot_sum [idda_pkg::RING_DEPTH];
  int unsigned      slot_cnt [idda_pkg::RING_DEPTH];
  logic [idda_pkg::TIME_W-1:0] step_cnt;
  int unsigned      ring_ptr;
  bit               warmed;

  avg_res_t pending_avgs [$];
  int       errors = 0;
  int       cyc = 0;
  int       burst_left = 0;
  int       rmode = 0;

  stim_row_t rows [$];

  function automatic int unsigned ring_slot(longint signed offset);
    longint signed x;
    x = (longint'(ring_ptr) + offset) % idda_pkg::RING_DEPTH;
    if (x < 0) x += idda_pkg::RING_DEPTH;
    return int'(x);
  endfunction

  // advance predictor by one accepted request; returns 1 if it emits an average
  function automatic bit predict_average(idda_pkg::req_t req,
                                         logic [idda_pkg::CH_W-1:0] ch,
                                         logic signed [idda_pkg::VAL_W-1:0] val,
                                         logic eot, output avg_res_t res);
    longint signed d, s, sum, avg;
    int unsigned   k;
    bit            emit;
    emit = 1'b0;
    res = '{default: '0};
    if (req == idda_pkg::REQ_LOAD) begin
      d = val;
      if (d > idda_pkg::MAX_DELAY) d = idda_pkg::MAX_DELAY;
      if (d < -idda_pkg::MAX_DELAY) d = -idda_pkg::MAX_DELAY;
      if (ch < idda_pkg::NUM_CHANNELS) dly_tab[ch] = int'(d);
      return 1'b0;
    end
    if (req == idda_pkg::REQ_NONE) return 1'b0;
    if (req == idda_pkg::REQ_SAMPLE && ch < idda_pkg::NUM_CHANNELS) begin
      d = dly_tab[ch];
      if (warmed || (longint'(step_cnt) + d >= 0)) begin
        s = val;
        k = ring_slot(d);
        if (slot_cnt[k] < idda_pkg::CNT_MAX) begin
          sum = slot_sum[k] + s;
          if (sum > 8388607) sum = 8388607;
          if (sum < -8388608) sum = -8388608;
          slot_sum[k] = sum;
          slot_cnt[k]++;
        end
      end
    end
    if (req == idda_pkg::REQ_FLUSH || eot) begin
      if (warmed || step_cnt >= idda_pkg::MAX_DELAY) begin
        k = ring_slot(-idda_pkg::MAX_DELAY);
        avg = 0;
        res.emp = 1'b1;
        if (slot_cnt[k] != 0) begin
          avg = slot_sum[k] / longint'(slot_cnt[k]);
          if (avg > 32767) avg = 32767;
          if (avg < -32768) avg = -32768;
          res.emp = 1'b0;
        end
        res.t = step_cnt - idda_pkg::MAX_DELAY;
        res.avg = avg[idda_pkg::AVG_W-1:0];
        slot_sum[k] = 0;
        slot_cnt[k] = 0;
        warmed = 1'b1;
        emit = 1'b1;
      end
      step_cnt++;
      ring_ptr = (ring_ptr + 1) % idda_pkg::RING_DEPTH;
    end
    return emit;
  endfunction

  // drive one request and hold it until transferred; bursts with random gaps
  task automatic send_req(stim_row_t r);
    avg_res_t res;
    int       gap;
    if (burst_left == 0) begin
      if ($urandom_range(0, 7) == 0) begin
        burst_left = 200;
        gap = 0;
      end else begin
        burst_left = $urandom_range(1, 32);
        gap = $urandom_range(0, 8);
      end
      if (gap > 0) begin
        samples_if.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    samples_if.valid       <= 1'b1;
    samples_if.req_type    <= r.req;
    samples_if.channel     <= r.ch;
    samples_if.value       <= r.val;
    samples_if.end_of_time <= r.eot;
    do @(posedge clk); while (!samples_if.ready);
    if (predict_average(r.req, r.ch, r.val, r.eot, res))
      pending_avgs.push_back(r.typed ? r.res : res);
  endtask

  function automatic stim_row_t mk(idda_pkg::req_t req, int ch, int val, bit eot);
    stim_row_t r;
    r.req = req;
    r.ch = ch[idda_pkg::CH_W-1:0];
    r.val = val[idda_pkg::VAL_W-1:0];
    r.eot = eot;
    r.typed = 1'b0;
    r.res = '{default: '0};
    return r;
  endfunction

  function automatic stim_row_t mk_typed(idda_pkg::req_t req, int ch, int val, bit eot,
                                         int t, int avg, bit emp);
    stim_row_t r;
    r = mk(req, ch, val, eot);
    r.typed = 1'b1;
    r.res.t = t;
    r.res.avg = avg[idda_pkg::AVG_W-1:0];
    r.res.emp = emp;
    return r;
  endfunction

  // result check and receiver stall pattern
  always @(posedge clk) begin
    avg_res_t e;
    cyc <= cyc + 1;
    if (cyc >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
    if (!rst && results_if.valid && results_if.ready) begin
      if (pending_avgs.size() == 0) begin
        $display("%0t: unexpected result t=%0d avg=%0d empty=%0b", $time,
                 results_if.time_index, results_if.average, results_if.empty_res);
        errors++;
      end else begin
        e = pending_avgs.pop_front();
        if (results_if.time_index !== e.t) begin
          $display("%0t: time_index expected %0d actual %0d", $time, e.t,
                   results_if.time_index);
          errors++;
        end
        if (results_if.average !== e.avg) begin
          $display("%0t: average expected %0d actual %0d", $time, e.avg,
                   results_if.average);
          errors++;
        end
        if (results_if.empty_res !== e.emp) begin
          $display("%0t: empty_res expected %0b actual %0b", $time, e.emp,
                   results_if.empty_res);
          errors++;
        end
      end
    end
    if (cyc % 256 == 0) rmode <= $urandom_range(0, 2);
    case (rmode)
      0: results_if.ready <= 1'b1;
      1: results_if.ready <= ($urandom_range(0, 1) == 1);
      default: results_if.ready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  initial begin
    stim_row_t r;
    int        warm_row;
    int        n;
    samples_if.valid       = 1'b0;
    samples_if.req_type    = idda_pkg::REQ_NONE;
    samples_if.channel     = '0;
    samples_if.value       = '0;
    samples_if.end_of_time = 1'b0;
    results_if.ready       = 1'b0;
    foreach (dly_tab[i]) dly_tab[i] = 0;
    foreach (slot_sum[i]) begin
      slot_sum[i] = 0;
      slot_cnt[i] = 0;
    end
    step_cnt = '0;
    ring_ptr = 0;
    warmed = 1'b0;

    // warm-up rows: loads with saturation, samples, a dropped early sample
    rows.push_back(mk(idda_pkg::REQ_LOAD, 0, 0, 1'b1));
    rows.push_back(mk(idda_pkg::REQ_LOAD, 1, 32767, 1'b0));
    rows.push_back(mk(idda_pkg::REQ_LOAD, 2, -32768, 1'b0));
    rows.push_back(mk(idda_pkg::REQ_LOAD, 255, -1, 1'b0));
    rows.push_back(mk(idda_pkg::REQ_SAMPLE, 0, -32768, 1'b0));
    rows.push_back(mk(idda_pkg::REQ_SAMPLE, 2, 100, 1'b0));
    rows.push_back(mk(idda_pkg::REQ_SAMPLE, 1, 32767, 1'b1));
    rows.push_back(mk(idda_pkg::REQ_NONE, 3, 1234, 1'b1));
    rows.push_back(mk(idda_pkg::REQ_FLUSH, 0, 0, 1'b0));
    warm_row = rows.size();
    // once warm: first outputs readable directly
    rows.push_back(mk_typed(idda_pkg::REQ_FLUSH, 0, 0, 1'b0, 0, -32768, 1'b0));
    rows.push_back(mk_typed(idda_pkg::REQ_FLUSH, 7, -1, 1'b1, 1, 0, 1'b1));
    rows.push_back(mk_typed(idda_pkg::REQ_SAMPLE, 2, 32767, 1'b1, 2, 32767, 1'b0));
    rows.push_back(mk(idda_pkg::REQ_SAMPLE, 2, -32768, 1'b0));
    rows.push_back(mk_typed(idda_pkg::REQ_SAMPLE, 2, -1, 1'b1, 3, -16384, 1'b0));
    rows.push_back(mk(idda_pkg::REQ_SAMPLE, 255, 5, 1'b1));
    rows.push_back(mk(idda_pkg::REQ_NONE, 255, -1, 1'b1));
    rows.push_back(mk(idda_pkg::REQ_LOAD, 3, 7, 1'b1));
    rows.push_back(mk(idda_pkg::REQ_SAMPLE, 3, 21845, 1'b1));

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < rows.size(); i++) begin
      if (i == warm_row) begin
        // flush through the warm-up period
        while (step_cnt < idda_pkg::MAX_DELAY)
          send_req(mk(idda_pkg::REQ_FLUSH, 0, 0, 1'b0));
      end
      send_req(rows[i]);
    end

    // drive one slot to full count with saturating sum
    send_req(mk(idda_pkg::REQ_LOAD, 9, -511, 1'b0));
    for (int i = 0; i < 520; i++)
      send_req(mk(idda_pkg::REQ_SAMPLE, 9, 32767, i == 519));

    n = 0;
    while (n < 450) begin
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 4) begin
        if ($urandom_range(0, 1))
          r = mk(idda_pkg::REQ_LOAD, int'($urandom), int'($urandom),
                 1'($urandom_range(0, 1)));
        else
          r = mk(idda_pkg::REQ_LOAD, int'($urandom),
                 int'($urandom_range(0, 1200)) - 600, 1'b0);
      end else if (pick < 7) begin
        r = mk(idda_pkg::REQ_FLUSH, int'($urandom), int'($urandom),
               1'($urandom_range(0, 1)));
      end else if (pick < 9) begin
        r = mk(idda_pkg::REQ_NONE, int'($urandom), int'($urandom),
               1'($urandom_range(0, 1)));
      end else begin
        r = mk(idda_pkg::REQ_SAMPLE, int'($urandom), int'($urandom),
               $urandom_range(0, 15) == 0);
      end
      send_req(r);
      if (r.req != idda_pkg::REQ_NONE) n++;
    end
    samples_if.valid <= 1'b0;

    while (pending_avgs.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
